### rtl/nuf_pkg.sv
// ----------------------------------------------------------------------------
// nuf_pkg
// shared types, receive mode codes, status codes and helpers for the
// nmea / ubx frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package nuf_pkg;

    localparam int NUF_MAX_FRAME_DEF = 128;
    localparam int NUF_LEN_W         = 13;

    // receive modes
    localparam logic [3:0] M_HUNT  = 4'd0;
    localparam logic [3:0] M_SYNC2 = 4'd1;
    localparam logic [3:0] M_NBODY = 4'd2;
    localparam logic [3:0] M_NTAIL = 4'd3;
    localparam logic [3:0] M_CLASS = 4'd4;
    localparam logic [3:0] M_IDENT = 4'd5;
    localparam logic [3:0] M_LENLO = 4'd6;
    localparam logic [3:0] M_LENHI = 4'd7;
    localparam logic [3:0] M_PAYLD = 4'd8;
    localparam logic [3:0] M_CKA   = 4'd9;
    localparam logic [3:0] M_CKB   = 4'd10;

    // frame status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_FORMAT   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // item kinds and frame types
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic TYPE_NMEA   = 1'b0;
    localparam logic TYPE_UBX    = 1'b1;

    // marker characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_SYNC1  = 8'hb5;
    localparam logic [7:0] CH_SYNC2  = 8'h62;

    typedef struct packed {
        logic [3:0]           mode;
        logic [7:0]           xor_sum;
        logic [7:0]           sum_a;
        logic [7:0]           sum_b;
        logic [7:0]           recv_sum_a;
        logic [15:0]          declared_length;
        logic [NUF_LEN_W-1:0] byte_count;
        logic [7:0]           class_reg;
        logic [7:0]           ident_reg;
        logic [1:0]           tail_count;
        logic [7:0]           tail_value;
        logic                 tail_hex_ok;
        logic                 pending_cr;
    } t_state;

    typedef struct packed {
        logic                 item_kind;
        logic [7:0]           data_byte;
        logic                 frame_type;
        logic [7:0]           msg_class;
        logic [7:0]           msg_ident;
        logic [NUF_LEN_W-1:0] body_length;
        logic [1:0]           frame_status;
    } t_result;

    // one checksum-tail character: saturating count, hex digit shift-in
    function automatic t_state tail_char(input t_state s, input logic [7:0] b);
        t_state     r;
        logic [3:0] d;
        logic       hex;
        r   = s;
        hex = 1'b1;
        d   = 4'd0;
        if (s.tail_count != 2'd3) begin
            r.tail_count = s.tail_count + 2'd1;
        end
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b[3:0];
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            d = b[3:0] + 4'd9;
        end else begin
            hex = 1'b0;
        end
        if (hex) begin
            r.tail_value = {s.tail_value[3:0], d};
        end else begin
            r.tail_hex_ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/nuf_in_if.sv
// ----------------------------------------------------------------------------
// nuf_in_if
// received byte channel, one serial byte per word
// ----------------------------------------------------------------------------
`default_nettype none

interface nuf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/nuf_out_if.sv
// ----------------------------------------------------------------------------
// nuf_out_if
// result channel, one body byte or end-of-frame status per word
// ----------------------------------------------------------------------------
`default_nettype none

interface nuf_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  data_byte;
    logic        frame_type;
    logic [7:0]  msg_class;
    logic [7:0]  msg_ident;
    logic [12:0] body_length;
    logic [1:0]  frame_status;

    modport source (output valid, output item_kind, output data_byte, output frame_type,
                    output msg_class, output msg_ident, output body_length,
                    output frame_status, input ready);
    modport sink   (input valid, input item_kind, input data_byte, input frame_type,
                    input msg_class, input msg_ident, input body_length,
                    input frame_status, output ready);
endinterface

`default_nettype wire

### rtl/nuf_step.sv
// ----------------------------------------------------------------------------
// nuf_step
// next-state and result logic for one received byte
// ----------------------------------------------------------------------------
`default_nettype none

module nuf_step
    import nuf_pkg::*;
#(
    parameter int MAX_FRAME = NUF_MAX_FRAME_DEF
) (
    input  var t_state     i_state,
    input  var logic [7:0] i_byte,
    output var t_state     o_state,
    output var logic       o_res_valid,
    output var t_result    o_res
);

    localparam logic [NUF_LEN_W-1:0] MAX_CNT = NUF_LEN_W'(MAX_FRAME);
    localparam logic [16:0]          MAX_SUM = 17'(MAX_FRAME);
    localparam logic [15:0]          MAX_DEC = 16'(MAX_FRAME);

    t_state      s;
    t_state      n;
    logic        rv;
    t_result     r;
    logic [7:0]  fa;
    logic [7:0]  fb;
    logic [15:0] dl;
    logic [NUF_LEN_W-1:0] nbc;
    logic [16:0] tail_sum;

    assign s = i_state;

    always_comb begin
        n        = s;
        rv       = 1'b0;
        r        = '0;
        fa       = s.sum_a + i_byte;
        fb       = s.sum_b + fa;
        dl       = {i_byte, s.declared_length[7:0]};
        nbc      = s.byte_count + NUF_LEN_W'(1);
        tail_sum = {{(17 - NUF_LEN_W){1'b0}}, s.byte_count} + {1'b0, s.declared_length};

        case (s.mode)
            M_NBODY: begin
                if (i_byte == CH_STAR) begin
                    n.mode            = M_NTAIL;
                    n.tail_count      = 2'd0;
                    n.tail_value      = 8'd0;
                    n.tail_hex_ok     = 1'b1;
                    n.pending_cr      = 1'b0;
                    n.declared_length = 16'd0;
                end else if (s.pending_cr && i_byte == CH_LF) begin
                    n.mode         = M_HUNT;
                    n.pending_cr   = 1'b0;
                    rv             = 1'b1;
                    r.item_kind    = KIND_STATUS;
                    r.frame_type   = TYPE_NMEA;
                    r.body_length  = s.byte_count;
                    r.frame_status = ST_FORMAT;
                end else if (s.byte_count >= MAX_CNT) begin
                    n.mode         = M_HUNT;
                    n.pending_cr   = 1'b0;
                    rv             = 1'b1;
                    r.item_kind    = KIND_STATUS;
                    r.frame_type   = TYPE_NMEA;
                    r.body_length  = s.byte_count;
                    r.frame_status = ST_OVERFLOW;
                end else begin
                    n.xor_sum     = s.xor_sum ^ i_byte;
                    n.byte_count  = nbc;
                    n.pending_cr  = (i_byte == CH_CR);
                    rv            = 1'b1;
                    r.item_kind   = KIND_BYTE;
                    r.data_byte   = i_byte;
                    r.frame_type  = TYPE_NMEA;
                    r.body_length = nbc;
                end
            end
            M_NTAIL: begin
                if (s.pending_cr && i_byte == CH_LF) begin
                    n.mode        = M_HUNT;
                    n.pending_cr  = 1'b0;
                    rv            = 1'b1;
                    r.item_kind   = KIND_STATUS;
                    r.frame_type  = TYPE_NMEA;
                    r.body_length = s.byte_count;
                    if (s.tail_count == 2'd2 && s.tail_hex_ok) begin
                        r.frame_status = (s.tail_value == s.xor_sum) ? ST_OK : ST_MISMATCH;
                    end else begin
                        r.frame_status = ST_FORMAT;
                    end
                end else if (tail_sum >= MAX_SUM) begin
                    n.mode         = M_HUNT;
                    n.pending_cr   = 1'b0;
                    rv             = 1'b1;
                    r.item_kind    = KIND_STATUS;
                    r.frame_type   = TYPE_NMEA;
                    r.body_length  = s.byte_count;
                    r.frame_status = ST_OVERFLOW;
                end else begin
                    n.declared_length = s.declared_length + 16'd1;
                    // a cr that was not followed by lf is a tail character
                    if (s.pending_cr) begin
                        n = tail_char(n, CH_CR);
                    end
                    if (i_byte == CH_CR) begin
                        n.pending_cr = 1'b1;
                    end else begin
                        n.pending_cr = 1'b0;
                        n = tail_char(n, i_byte);
                    end
                end
            end
            M_SYNC2: begin
                if (i_byte == CH_SYNC2) begin
                    n.mode = M_CLASS;
                end else if (i_byte == CH_DOLLAR) begin
                    n.mode            = M_NBODY;
                    n.xor_sum         = 8'd0;
                    n.byte_count      = '0;
                    n.declared_length = 16'd0;
                    n.pending_cr      = 1'b0;
                    n.class_reg       = 8'd0;
                    n.ident_reg       = 8'd0;
                end else if (i_byte == CH_SYNC1) begin
                    n.mode = M_SYNC2;
                end else begin
                    n.mode = M_HUNT;
                end
            end
            M_CLASS: begin
                n.sum_a      = i_byte;
                n.sum_b      = i_byte;
                n.class_reg  = i_byte;
                n.ident_reg  = 8'd0;
                n.byte_count = '0;
                n.mode       = M_IDENT;
            end
            M_IDENT: begin
                n.sum_a     = fa;
                n.sum_b     = fb;
                n.ident_reg = i_byte;
                n.mode      = M_LENLO;
            end
            M_LENLO: begin
                n.sum_a           = fa;
                n.sum_b           = fb;
                n.declared_length = {8'd0, i_byte};
                n.mode            = M_LENHI;
            end
            M_LENHI: begin
                n.sum_a           = fa;
                n.sum_b           = fb;
                n.declared_length = dl;
                if (dl > MAX_DEC) begin
                    n.mode         = M_HUNT;
                    n.pending_cr   = 1'b0;
                    rv             = 1'b1;
                    r.item_kind    = KIND_STATUS;
                    r.frame_type   = TYPE_UBX;
                    r.msg_class    = s.class_reg;
                    r.msg_ident    = s.ident_reg;
                    r.body_length  = s.byte_count;
                    r.frame_status = ST_OVERFLOW;
                end else begin
                    n.mode = (dl == 16'd0) ? M_CKA : M_PAYLD;
                end
            end
            M_PAYLD: begin
                n.sum_a      = fa;
                n.sum_b      = fb;
                n.byte_count = nbc;
                if ({{(16 - NUF_LEN_W){1'b0}}, nbc} >= s.declared_length) begin
                    n.mode = M_CKA;
                end
                rv            = 1'b1;
                r.item_kind   = KIND_BYTE;
                r.data_byte   = i_byte;
                r.frame_type  = TYPE_UBX;
                r.msg_class   = s.class_reg;
                r.msg_ident   = s.ident_reg;
                r.body_length = nbc;
            end
            M_CKA: begin
                n.recv_sum_a = i_byte;
                n.mode       = M_CKB;
            end
            M_CKB: begin
                n.mode         = M_HUNT;
                n.pending_cr   = 1'b0;
                rv             = 1'b1;
                r.item_kind    = KIND_STATUS;
                r.frame_type   = TYPE_UBX;
                r.msg_class    = s.class_reg;
                r.msg_ident    = s.ident_reg;
                r.body_length  = s.byte_count;
                r.frame_status = (s.recv_sum_a == s.sum_a && i_byte == s.sum_b)
                                 ? ST_OK : ST_MISMATCH;
            end
            default: begin
                // hunting, and any unused mode code
                if (i_byte == CH_DOLLAR) begin
                    n.mode            = M_NBODY;
                    n.xor_sum         = 8'd0;
                    n.byte_count      = '0;
                    n.declared_length = 16'd0;
                    n.pending_cr      = 1'b0;
                    n.class_reg       = 8'd0;
                    n.ident_reg       = 8'd0;
                end else if (i_byte == CH_SYNC1) begin
                    n.mode = M_SYNC2;
                end else begin
                    n.mode = M_HUNT;
                end
            end
        endcase
    end

    assign o_state     = n;
    assign o_res_valid = rv;
    assign o_res       = r;

endmodule

`default_nettype wire

### rtl/nmea_ubx_frame_receiver.sv
// ----------------------------------------------------------------------------
// nmea_ubx_frame_receiver
// deframes nmea 0183 sentences and ubx binary frames from a serial byte stream
// ----------------------------------------------------------------------------
// usage:
//   i_in carries received serial bytes, one per word. junk outside a frame
//   is skipped until '$' (nmea) or b5 62 (ubx) is seen.
//   o_out carries one word per nmea body byte or ubx payload byte, and one
//   end-of-frame status word per frame (ok, checksum mismatch, bad checksum
//   format, overflow). bytes that cause no result produce no word.
//   a byte accepted is held in the input register, and its result word is
//   then registered in the result register, from which o_out is driven.
//   throughput: one byte per cycle while o_out is not held, set by the
//   combinational step logic between the input and result registers.
//   stall: while o_out is held and a result waits, the input register still
//   takes one more byte; further bytes wait with i_in.ready low.
//   reset: i_rst_n low (synchronous) empties both registers and puts the
//   receiver back to hunting with all checksums and counters cleared.
//   MAX_FRAME limits the body length of a frame (up to 8191 for 13-bit lengths).
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_ubx_frame_receiver
    import nuf_pkg::*;
#(
    parameter int MAX_FRAME = NUF_MAX_FRAME_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    nuf_in_if.sink    i_in,
    nuf_out_if.source o_out
);

    // hunting, all sums and counters cleared, hex flag set
    localparam t_state STATE_RST = '{mode: M_HUNT, tail_hex_ok: 1'b1, default: '0};

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // receiver state
    t_state     r_state;
    t_state     n_state;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    logic       w_res_valid;
    t_result    w_res;
    logic       w_adv;
    logic       w_in_acc;

    // the held byte moves on once the result slot is free or being emptied
    assign w_adv    = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_acc = i_in.valid && i_in.ready;

    assign i_in.ready = !r_in_valid || w_adv;

    nuf_step #(
        .MAX_FRAME (MAX_FRAME)
    ) u_step (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .o_state     (n_state),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_in.rx_byte;
        end
    end

    // receiver state, updated once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RST;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.item_kind    = r_out.item_kind;
    assign o_out.data_byte    = r_out.data_byte;
    assign o_out.frame_type   = r_out.frame_type;
    assign o_out.msg_class    = r_out.msg_class;
    assign o_out.msg_ident    = r_out.msg_ident;
    assign o_out.body_length  = r_out.body_length;
    assign o_out.frame_status = r_out.frame_status;

    // a status word always sends the receiver back to hunting
    a_status_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_res_valid && w_res.item_kind == KIND_STATUS)
        |=> (r_state.mode == M_HUNT))
        else $error("status word without return to hunting");

    // byte words carry an ok status
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_out.item_kind == KIND_BYTE) |-> (o_out.frame_status == ST_OK))
        else $error("byte word with non-ok status");

    // body length never passes the frame limit
    a_len_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_out.body_length <= NUF_LEN_W'(MAX_FRAME)))
        else $error("body length above frame limit");

    // nmea words carry no class or id
    a_nmea_noid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_out.frame_type == TYPE_NMEA)
        |-> (o_out.msg_class == 8'd0 && o_out.msg_ident == 8'd0))
        else $error("nmea word with class or id");

    // a stalled result keeps the input register from advancing
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready && r_in_valid) |=> r_in_valid)
        else $error("held byte lost during output stall");

endmodule

`default_nettype wire
